### rtl/ordered_value_list_macros.svh
// Assertion macros shared by the RTL.
`ifndef ORDERED_VALUE_LIST_MACROS_SVH
`define ORDERED_VALUE_LIST_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define OVL_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ordered_value_list: assertion failed");

// Next-cycle implication, disabled during reset.
`define OVL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ordered_value_list: assertion failed");

`else

`define OVL_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define OVL_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### rtl/ovl_pkg.sv
`default_nettype none

package ovl_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    typedef logic [VAL_W-1:0] val_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    // Broadcast from control to every cell.
    typedef struct packed {
        logic ins;
        logic del;
        logic rot;
        val_t key;
    } cell_ctl_t;

    // Gathered from the chain for control.
    typedef struct packed {
        logic                found;
        logic [CAPACITY-1:0] occ;
        val_t                head;
    } chain_sts_t;

endpackage

`default_nettype wire

### rtl/ovl_cell.sv
`default_nettype none

module ovl_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ovl_pkg::cell_ctl_t ctl,
    input  wire logic              left_occ,
    input  wire logic              left_hit,
    input  wire logic              right_occ,
    input  wire ovl_pkg::val_t     right_data,
    input  wire ovl_pkg::val_t     head_data,
    output logic                   occ,
    output ovl_pkg::val_t          data,
    output logic                   hit
);
    import ovl_pkg::*;

    logic occ_reg, occ_next;
    val_t data_reg, data_next;

    // hit: this cell or an older one holds the key
    assign hit  = left_hit | (occ_reg && (data_reg == ctl.key));
    assign occ  = occ_reg;
    assign data = data_reg;

    always_comb begin
        occ_next  = occ_reg;
        data_next = data_reg;
        if (ctl.ins && left_occ && !occ_reg) begin
            occ_next  = 1'b1;
            data_next = ctl.key;
        end else if (ctl.del && hit) begin
            // close the gap behind the first match
            occ_next  = right_occ;
            data_next = right_data;
        end else if (ctl.rot && occ_reg) begin
            // tail wraps to the head value
            data_next = right_occ ? right_data : head_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

### rtl/ovl_ctrl.sv
`default_nettype none
`include "ordered_value_list_macros.svh"

module ovl_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [31:0]         s_tdata,
    input  wire logic [1:0]          s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [31:0]              m_tdata,
    output logic [3:0]               m_tuser,
    output logic                     m_tlast,
    output ovl_pkg::cell_ctl_t       ctl,
    input  wire ovl_pkg::chain_sts_t sts
);
    import ovl_pkg::*;

    state_t     state_reg, state_next;
    cnt_t       count_reg, count_next;
    cnt_t       rem_reg, rem_next;
    logic       mval_reg, mval_next;
    val_t       mdata_reg, mdata_next;
    logic [3:0] muser_reg, muser_next;
    logic       mlast_reg, mlast_next;

    logic out_free;
    logic acc;
    logic full;
    op_t  op;

    assign out_free = !mval_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign acc      = s_tvalid && s_tready;
    assign full     = sts.occ[CAPACITY-1];
    assign op       = op_t'(s_tuser);

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign m_tlast  = mlast_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        mval_next  = mval_reg;
        mdata_next = mdata_reg;
        muser_next = muser_reg;
        mlast_next = mlast_reg;
        ctl        = '0;
        ctl.key    = s_tdata;

        if (m_tready) begin
            mval_next = 1'b0;
        end

        if (acc) begin
            mval_next  = 1'b1;
            mdata_next = '0;
            mlast_next = 1'b1;
            // tuser: {entry_valid, found, status}
            muser_next = {1'b0, 1'b0, ST_OK};
            case (op)
                OP_INSERT: begin
                    ctl.ins = 1'b1;
                    if (full) begin
                        muser_next = {1'b0, 1'b0, ST_FULL};
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_DELETE: begin
                    ctl.del = 1'b1;
                    if (sts.found) begin
                        muser_next = {1'b0, 1'b1, ST_OK};
                        count_next = count_reg - CNT_W'(1);
                    end else begin
                        muser_next = {1'b0, 1'b0, ST_NOT_FOUND};
                    end
                end
                OP_SEARCH: begin
                    if (sts.found) begin
                        muser_next = {1'b0, 1'b1, ST_OK};
                    end else begin
                        muser_next = {1'b0, 1'b0, ST_NOT_FOUND};
                    end
                end
                OP_LIST: begin
                    if (count_reg != '0) begin
                        mval_next  = 1'b0;
                        state_next = S_DUMP;
                        rem_next   = count_reg;
                    end
                end
                default: begin
                end
            endcase
        end

        if ((state_reg == S_DUMP) && out_free) begin
            ctl.rot    = 1'b1;
            mval_next  = 1'b1;
            mdata_next = sts.head;
            muser_next = {1'b1, 1'b0, ST_OK};
            mlast_next = (rem_reg == CNT_W'(1));
            rem_next   = rem_reg - CNT_W'(1);
            if (rem_reg == CNT_W'(1)) begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
        mlast_reg <= mlast_next;
    end

    `OVL_ASSERT_IMPL(a_count_matches_cells, aclk, aresetn, 1'b1,
        (32'(count_reg) == 32'($countones(sts.occ))))
    `OVL_ASSERT_IMPL(a_dump_not_empty, aclk, aresetn, state_reg == S_DUMP,
        (count_reg != '0) && (rem_reg != '0) && !s_tready)
    `OVL_ASSERT_NEXT(a_dump_holds_list, aclk, aresetn, state_reg == S_DUMP,
        $stable(count_reg))

endmodule

`default_nettype wire

### rtl/ordered_value_list.sv
// ordered_value_list: bounded insertion-ordered list, one cell per entry.
// Insert, delete and search: result registered the next cycle; one such item per
// cycle while idle and the output is free, all cells compare the key in parallel.
// List: blocks input until the dump ends, one beat per cycle while the output is free,
// as the chain rotates entries through the head cell; an empty list gives one beat.
// Reset (aresetn low, synchronous): list empty, no result pending; cell data is not cleared.
`default_nettype none

module ordered_value_list (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    // result beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] entry_value
    output logic [3:0]       m_tuser,   // [1:0] status, [2] found, [3] entry_valid
    output logic             m_tlast
);
    import ovl_pkg::*;

    cell_ctl_t  ctl;
    chain_sts_t sts;

    // Neighbor links padded at both ends: index 0 is left of the head cell,
    // index CAPACITY+1 is right of the tail cell. Cell i sits at index i+1.
    logic [CAPACITY+1:0] occ_c;
    val_t                data_c [CAPACITY+2];
    logic [CAPACITY:0]   hit_c;

    assign occ_c[0]            = 1'b1;  // head cell always sees an occupied left
    assign occ_c[CAPACITY+1]   = 1'b0;
    assign data_c[0]           = '0;
    assign data_c[CAPACITY+1]  = '0;
    assign hit_c[0]            = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        ovl_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .left_occ   (occ_c[i]),
            .left_hit   (hit_c[i]),
            .right_occ  (occ_c[i+2]),
            .right_data (data_c[i+2]),
            .head_data  (data_c[1]),
            .occ        (occ_c[i+1]),
            .data       (data_c[i+1]),
            .hit        (hit_c[i+1])
        );
    end

    // found: prefix match reached the tail end
    assign sts.found = hit_c[CAPACITY];
    assign sts.occ   = occ_c[CAPACITY:1];
    assign sts.head  = data_c[1];

    ovl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .ctl      (ctl),
        .sts      (sts)
    );

endmodule

`default_nettype wire

### test/ordered_value_list_tb.sv
`timescale 1ns / 100ps

module ordered_value_list_tb;
    import ovl_pkg::*;

    // Every beat makes at least one result, so a long quiet stretch means a hang.
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;     // long receiver hold-off, fills the block
    localparam int TAIL_CYCLES = 40;     // settle time after the last result
    localparam int MAX_REPORTS = 40;

    localparam val_t VAL_MIN  = 32'h8000_0000;
    localparam val_t VAL_MAX  = 32'h7fff_ffff;
    localparam val_t VAL_ZERO = 32'h0000_0000;
    localparam val_t VAL_ONES = 32'hffff_ffff;

    // One result beat as the block should send it.
    typedef struct packed {
        logic [1:0] status;
        logic       found;
        val_t       value;
        logic       valid;
        logic       last;
    } list_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [31:0] value
    logic [1:0]  s_tuser  = '0;    // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [31:0] entry_value
    logic [3:0]  m_tuser;          // [1:0] status, [2] found, [3] entry_valid
    logic        m_tlast;

    // Shadow copy of the list, updated on every accepted input beat.
    val_t         list_cells [CAPACITY];
    int           list_fill = 0;
    list_result_t pending_results[$];

    int mismatches     = 0;
    int stall_cycles   = 0;
    bit no_idle        = 1'b0;   // both sides run flat out while set
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;

    ordered_value_list dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    endtask

    function automatic list_result_t make_result(input logic [1:0] status,
                                                 input logic found, input val_t value,
                                                 input logic valid, input logic last);
        list_result_t r;
        r.status = status;
        r.found  = found;
        r.value  = value;
        r.valid  = valid;
        r.last   = last;
        return r;
    endfunction

    // Shadow list update and expected beats for one accepted input beat.
    task automatic apply_beat(input op_t op, input val_t v);
        int hit;
        hit = list_fill;
        for (int i = list_fill - 1; i >= 0; i--)
            if (list_cells[i] == v) hit = i;   // oldest match wins
        case (op)
            OP_INSERT: begin
                if (list_fill >= CAPACITY) begin
                    pending_results.push_back(make_result(ST_FULL, 1'b0, '0, 1'b0, 1'b1));
                end else begin
                    list_cells[list_fill] = v;
                    list_fill++;
                    pending_results.push_back(make_result(ST_OK, 1'b0, '0, 1'b0, 1'b1));
                end
            end
            OP_DELETE: begin
                if (hit == list_fill) begin
                    pending_results.push_back(
                        make_result(ST_NOT_FOUND, 1'b0, '0, 1'b0, 1'b1));
                end else begin
                    // close the gap; covers head, middle, tail and the only entry
                    for (int i = hit; i + 1 < list_fill; i++)
                        list_cells[i] = list_cells[i + 1];
                    list_fill--;
                    pending_results.push_back(make_result(ST_OK, 1'b1, '0, 1'b0, 1'b1));
                end
            end
            OP_SEARCH: begin
                if (hit == list_fill)
                    pending_results.push_back(
                        make_result(ST_NOT_FOUND, 1'b0, '0, 1'b0, 1'b1));
                else
                    pending_results.push_back(make_result(ST_OK, 1'b1, '0, 1'b0, 1'b1));
            end
            default: begin
                if (list_fill == 0)
                    pending_results.push_back(make_result(ST_OK, 1'b0, '0, 1'b0, 1'b1));
                for (int i = 0; i < list_fill; i++)
                    pending_results.push_back(make_result(ST_OK, 1'b0, list_cells[i],
                                                          1'b1, i + 1 == list_fill));
            end
        endcase
    endtask

    // Input monitor and result checker share one process, so a beat is always
    // predicted before any result it causes is compared.
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                apply_beat(op_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected result beat", m_tdata, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser[1:0] !== want.status)
                        flag_mismatch("status", m_tuser[1:0], want.status);
                    if (m_tuser[2] !== want.found)
                        flag_mismatch("found", m_tuser[2], want.found);
                    if (m_tdata !== want.value)
                        flag_mismatch("entry_value", m_tdata, want.value);
                    if (m_tuser[3] !== want.valid)
                        flag_mismatch("entry_valid", m_tuser[3], want.valid);
                    if (m_tlast !== want.last)
                        flag_mismatch("last", m_tlast, want.last);
                end
            end
        end
    end

    // Receiver: random stalls, a counted hold-off on request, none while no_idle.
    always @(posedge aclk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 23);
        end
    end

    // Watchdog on handshake progress.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one beat and hold it until the block takes it. Called at a rising edge.
    task automatic send_beat(input op_t op, input val_t v);
        if (!no_idle && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Sender pause: nothing offered until every expected result is back.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Half the time values already held, so deletes and searches hit; some duplicates
    // from a narrow pool, some extremes, the rest fully random.
    function automatic val_t pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 50 && list_fill > 0)
            return list_cells[$urandom_range(list_fill - 1)];
        if (r < 70)
            return val_t'($urandom_range(4)) - val_t'(2);
        if (r < 80) begin
            case ($urandom_range(3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return VAL_ZERO;
                default: return VAL_ONES;
            endcase
        end
        return $urandom();
    endfunction

    task automatic random_beat();
        int r;
        r = $urandom_range(99);
        if (list_fill >= CAPACITY - 1 && r < 40)
            r = r + 40;    // near full: lean toward deletes
        if (r < 40)
            send_beat(OP_INSERT, pick_value());
        else if (r < 65)
            send_beat(OP_DELETE, pick_value());
        else if (r < 85)
            send_beat(OP_SEARCH, pick_value());
        else
            send_beat(OP_LIST, $urandom());
    endtask

    task automatic test_empty_list();
        send_beat(OP_LIST, VAL_ONES);
        send_beat(OP_SEARCH, $urandom());
        send_beat(OP_DELETE, $urandom());
    endtask

    // Removing the only entry must leave an empty list.
    task automatic test_single_entry();
        val_t v;
        v = $urandom();
        send_beat(OP_INSERT, v);
        send_beat(OP_DELETE, v);
        send_beat(OP_LIST, VAL_ZERO);
    endtask

    // Extremes, a duplicate, oldest-match delete, then a tail delete.
    task automatic test_extreme_values();
        send_beat(OP_INSERT, VAL_MIN);
        send_beat(OP_INSERT, VAL_MAX);
        send_beat(OP_INSERT, VAL_ZERO);
        send_beat(OP_INSERT, VAL_ONES);
        send_beat(OP_INSERT, VAL_MAX);
        send_beat(OP_SEARCH, VAL_MIN);
        send_beat(OP_DELETE, VAL_MAX);   // oldest copy goes
        send_beat(OP_DELETE, VAL_MAX);   // now the tail
        send_beat(OP_SEARCH, VAL_MAX);
        send_beat(OP_LIST, VAL_MAX);
    endtask

    // Fill to capacity, overflow, dump, then delete head and tail.
    task automatic test_full_list();
        val_t head_v;
        val_t tail_v;
        wait_results_drained();
        repeat (CAPACITY - list_fill + 2) send_beat(OP_INSERT, $urandom());
        wait_results_drained();
        head_v = list_cells[0];
        tail_v = list_cells[CAPACITY - 1];
        send_beat(OP_LIST, $urandom());
        send_beat(OP_SEARCH, tail_v);
        send_beat(OP_DELETE, head_v);
        send_beat(OP_DELETE, tail_v);
        send_beat(OP_LIST, $urandom());
    endtask

    // Receiver holds off while beats keep coming, then the sender drains.
    task automatic test_backpressure();
        hold_requests++;
        send_beat(OP_LIST, $urandom());
        repeat (20) random_beat();
        wait_results_drained();
    endtask

    task automatic test_random_mix(input int beats);
        repeat (beats) random_beat();
    endtask

    task automatic test_steady_stream();
        no_idle = 1'b1;
        repeat (25) random_beat();
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_list();
        test_single_entry();
        test_extreme_values();
        test_full_list();
        test_backpressure();
        test_random_mix(28);
        test_steady_stream();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            flag_mismatch("results never sent", pending_results.size(), 0);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/ovl_pkg.sv
rtl/ovl_cell.sv
rtl/ovl_ctrl.sv
rtl/ordered_value_list.sv
test/ordered_value_list_tb.sv
